[design/b2r_pkg.sv]
// shared types and constants for the bfloat16 to rgb8 pixel converter
// no dependencies; imported by b2r_chan and the top level
package b2r_pkg;

  typedef logic [15:0] bf16_word_t;
  typedef logic [7:0]  pix_byte_t;

  // number of register stages from input transaction to output register
  localparam int PIPE_DEPTH = 5;

  // biased exponent codes of interest
  localparam logic [7:0] EXP_INF  = 8'd255;
  localparam logic [7:0] EXP_ONE  = 8'd127;
  localparam logic [7:0] EXP_TINY = 8'd97;
  // exponent offset that turns the biased exponent into the shift of v/2 scaled by 2^40
  localparam logic [7:0] EXP_SHIFT_BASE = 8'd95;

  // fixed results of the special cases
  localparam pix_byte_t BYTE_ZERO = 8'd0;
  localparam pix_byte_t BYTE_FULL = 8'd255;
  localparam pix_byte_t BYTE_MID  = 8'd128;

  // 0.5 with 40 fraction bits
  localparam logic [40:0] HALF_FIX = 41'h1 << 39;

endpackage

[design/b2r_chan.sv]
// datapath of one colour channel: bfloat16 word to unsigned byte in five stages
// depends on b2r_pkg; the pipeline enable comes from the top level
module b2r_chan
  import b2r_pkg::*;
(
  input  logic       clk,
  input  logic       en,
  input  bf16_word_t word_in,
  output pix_byte_t  byte_out
);

  // stage 1 registers: exact sum 0.5 + v/2 with 40 fraction bits
  logic [40:0] s1_sum;
  logic        s1_neg;
  logic        s1_spec;
  pix_byte_t   s1_sbyte;
  // stage 2 registers: sum rounded to single, in units of 2^-25
  logic [25:0] s2_sum;
  logic        s2_spec;
  pix_byte_t   s2_sbyte;
  // stage 3 registers: exact product by 255
  logic [33:0] s3_prod;
  logic        s3_spec;
  pix_byte_t   s3_sbyte;
  // stage 4 registers: product and its rounding shift
  logic [33:0] s4_prod;
  logic [3:0]  s4_sh;
  logic        s4_spec;
  pix_byte_t   s4_sbyte;

  // stage 1 logic: decode, classify and form the sum
  logic        a_sign;
  logic [7:0]  a_exp;
  logic [6:0]  a_frac;
  logic [4:0]  a_shift;
  logic [40:0] a_half_mag;
  logic [40:0] a_sum;
  logic        a_spec;
  pix_byte_t   a_sbyte;

  always_comb begin
    a_sign     = word_in[15];
    a_exp      = word_in[14:7];
    a_frac     = word_in[6:0];
    a_shift    = 5'(a_exp - EXP_SHIFT_BASE);
    a_half_mag = {33'd0, 1'b1, a_frac} << a_shift;
    a_sum      = a_sign ? (HALF_FIX - a_half_mag) : (HALF_FIX + a_half_mag);
    a_spec     = 1'b1;
    a_sbyte    = BYTE_MID;
    if (a_exp == EXP_INF) begin
      // nan gives zero, infinities saturate
      a_sbyte = ((a_frac != 7'd0) || a_sign) ? BYTE_ZERO : BYTE_FULL;
    end else if (a_exp >= EXP_ONE) begin
      a_sbyte = a_sign ? BYTE_ZERO : BYTE_FULL;
    end else if (a_exp < EXP_TINY) begin
      a_sbyte = BYTE_MID;
    end else begin
      a_spec = 1'b0;
    end
  end

  // stage 2 logic: round to 24 bits; leading one sits at bit 39 when
  // positive and at bit 38 or lower (exact then) when negative
  logic        b_up_pos;
  logic        b_up_neg;
  logic [25:0] b_sum;

  always_comb begin
    b_up_pos = s1_sum[15] && ((s1_sum[14:0] != 15'd0) || s1_sum[16]);
    b_up_neg = s1_sum[14] && ((s1_sum[13:0] != 14'd0) || s1_sum[15]);
    if (s1_neg) begin
      b_sum = s1_sum[40:15] + 26'(b_up_neg);
    end else begin
      b_sum = {s1_sum[40:16] + 25'(b_up_pos), 1'b0};
    end
  end

  // stage 3 logic: times 255 as shift and subtract
  logic [33:0] c_prod;

  always_comb begin
    c_prod = {s2_sum, 8'd0} - {8'd0, s2_sum};
  end

  // stage 4 logic: leading one search and rounding shift
  logic [5:0] d_pos;
  logic [3:0] d_sh;

  always_comb begin
    d_pos = 6'd0;
    for (int i = 0; i < 34; i++) begin
      if (s3_prod[i]) begin
        d_pos = 6'(i);
      end
    end
    d_sh = (d_pos > 6'd23) ? 4'(d_pos - 6'd23) : 4'd0;
  end

  // stage 5 logic: round product to 24 bits, then half up to a byte
  logic [33:0] e_mask;
  logic [33:0] e_half;
  logic [33:0] e_rem;
  logic [33:0] e_q;
  logic        e_up;
  logic [34:0] e_t;
  logic [34:0] e_tb;
  pix_byte_t   e_byte;

  always_comb begin
    e_mask = (34'd1 << s4_sh) - 34'd1;
    e_half = e_mask ^ (e_mask >> 1);
    e_rem  = s4_prod & e_mask;
    e_q    = s4_prod >> s4_sh;
    e_up   = (s4_sh != 4'd0) &&
             ((e_rem > e_half) || ((e_rem == e_half) && e_q[0]));
    e_t    = {1'b0, e_q + 34'(e_up)} << s4_sh;
    e_tb   = e_t + (35'd1 << 24);
    e_byte = s4_spec ? s4_sbyte : e_tb[32:25];
  end

  // pipeline registers, all advance together
  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum   <= a_sum;
      s1_neg   <= a_sign;
      s1_spec  <= a_spec;
      s1_sbyte <= a_sbyte;
      s2_sum   <= b_sum;
      s2_spec  <= s1_spec;
      s2_sbyte <= s1_sbyte;
      s3_prod  <= c_prod;
      s3_spec  <= s2_spec;
      s3_sbyte <= s2_sbyte;
      s4_prod  <= s3_prod;
      s4_sh    <= d_sh;
      s4_spec  <= s3_spec;
      s4_sbyte <= s3_sbyte;
      byte_out <= e_byte;
    end
  end

endmodule

[design/bf16_signed_to_rgb8_pixel_unit.sv]
// Top level of the bfloat16 signed to rgb8 pixel converter.
// Depends on b2r_pkg and three instances of b2r_chan.
//
// Usage:
//   s_* carries one pixel per transaction: three bfloat16 words in the
//   range -1 to 1. m_* returns the three bytes (v*0.5+0.5 clamped to
//   [0,1], times 255, rounded half away from zero, single-precision
//   rounding at every step). NaN gives 0, infinities saturate.
//   An input transaction passes the five register stages before m_tvalid:
//   sum, first rounding, multiply by 255, leading
//   one search, second rounding and byte.
//   Throughput is one pixel per cycle while m_tready stays high.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and s_tready drops; empty stages do not fill during the stall,
//   since s_tready is high only when the output register is empty or being taken.
//   A synchronous reset empties the pipeline; data registers are not
//   cleared and carry no meaning until their valid bit is set.
module bf16_signed_to_rgb8_pixel_unit
  import b2r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // red_half [15:0], green_half [31:16], blue_half [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // red_byte [7:0], green_byte [15:8], blue_byte [23:16]
);

  logic [PIPE_DEPTH-1:0] valid;
  logic                  en;
  pix_byte_t             red_byte;
  pix_byte_t             green_byte;
  pix_byte_t             blue_byte;

  // global advance: the output register is free or being taken
  assign en       = !valid[PIPE_DEPTH-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = valid[PIPE_DEPTH-1];
  assign m_tdata  = {blue_byte, green_byte, red_byte};

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[PIPE_DEPTH-2:0], s_tvalid};
    end
  end

  // one datapath per colour channel
  b2r_chan u_red (
    .clk      (clk),
    .en       (en),
    .word_in  (s_tdata[15:0]),
    .byte_out (red_byte)
  );

  b2r_chan u_green (
    .clk      (clk),
    .en       (en),
    .word_in  (s_tdata[31:16]),
    .byte_out (green_byte)
  );

  b2r_chan u_blue (
    .clk      (clk),
    .en       (en),
    .word_in  (s_tdata[47:32]),
    .byte_out (blue_byte)
  );

  // pipeline empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> (valid == '0))
    else $error("pipeline not empty after reset");

  // a stalled output freezes every valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(valid))
    else $error("pipeline moved during stall");

  // an accepted pixel enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> valid[0])
    else $error("accepted pixel lost at entry");

  // a result is not dropped while the receiver is not ready
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid)
    else $error("result dropped while stalled");

endmodule
